@@ hdl/cruise_throttle_input_controller_defines.svh @@
// Assertion macros used by the controller's back end.
`ifndef CRUISE_THROTTLE_INPUT_CONTROLLER_DEFINES_SVH
`define CRUISE_THROTTLE_INPUT_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CTIC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CTIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ctic_pkg.sv @@
package ctic_pkg;

  // Item kinds carried on the input tuser bit.
  localparam logic FUNC_CONTROL = 1'b0;
  localparam logic FUNC_PULSE   = 1'b1;

  // Pulse width clamp limits in microseconds.
  localparam int unsigned PW_MIN = 381;
  localparam int unsigned PW_MAX = 2937;

  // Largest percentage value.
  localparam logic [6:0] PCT_MAX = 7'd100;

  // Configuration port.
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] CFG_ADDR_INTERVAL = 3'd0;
  localparam logic [15:0] INTERVAL_RESET = 16'd50;

  // Status bit positions.
  localparam int unsigned ST_BRAKE  = 0;
  localparam int unsigned ST_MINUS  = 1;
  localparam int unsigned ST_PLUS   = 2;
  localparam int unsigned ST_CRUISE = 3;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    logic        func;
    logic [6:0]  pct;
    logic        brake;
    logic        cruise;
    logic        plus;
    logic        minus;
    logic [31:0] now_ms;
  } item_t;

endpackage

@@ hdl/ctic_front.sv @@
module ctic_front
  import ctic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  // Reciprocal constants: pct = d * 100 / 2556 and pct = a * 100 / 1023,
  // each folded into one multiply by a constant and a right shift.
  localparam logic [21:0] PW_RECIP = 22'd2625550;
  localparam logic [23:0] AN_RECIP = 24'd13120100;
  localparam logic [15:0] PW_LO    = 16'(PW_MIN);
  localparam logic [15:0] PW_HI    = 16'(PW_MAX);
  localparam logic [11:0] PW_SPAN  = 12'(PW_MAX - PW_MIN);

  logic        valid_r, valid_nxt;
  item_t       item_r, item_nxt;
  logic        accept;
  logic [15:0] pw;
  logic [9:0]  an;
  logic [11:0] pw_off;
  logic [33:0] pw_prod;
  logic [33:0] an_prod;

  assign pw = in_tdata[15:0];
  assign an = in_tdata[25:16];

  assign in_tready = !valid_r || q_ready;
  assign accept    = in_tvalid && in_tready;

  // Clamp the pulse width and scale both readings to percent.
  always_comb begin
    if (pw < PW_LO) begin
      pw_off = '0;
    end else if (pw > PW_HI) begin
      pw_off = PW_SPAN;
    end else begin
      pw_off = 12'(pw - PW_LO);
    end
    pw_prod = 34'(pw_off) * 34'(PW_RECIP);
    an_prod = 34'(an) * 34'(AN_RECIP);
  end

  // Build the classified item.
  always_comb begin
    item_nxt.func   = in_tuser;
    item_nxt.pct    = (in_tuser == FUNC_PULSE) ? pw_prod[32:26] : an_prod[33:27];
    item_nxt.brake  = in_tdata[26];
    item_nxt.cruise = in_tdata[27];
    item_nxt.plus   = in_tdata[28];
    item_nxt.minus  = in_tdata[29];
    item_nxt.now_ms = in_tdata[61:30];
  end

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule

@@ hdl/ctic_queue.sv @@
module ctic_queue
  import ctic_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign wr_ready = (count_r != CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ hdl/ctic_back.sv @@
`include "cruise_throttle_input_controller_defines.svh"

module ctic_back
  import ctic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] interval,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tuser
);

  logic        pop;
  logic        send_due;
  logic [31:0] elapsed;
  logic [7:0]  pct_sum;
  logic        plus_upd, minus_upd;
  logic [3:0]  status;

  logic [6:0]  pwm_percent_r, pwm_percent_nxt;
  logic [6:0]  throttle_hold_r, throttle_hold_nxt;
  logic        brake_prev_r, brake_prev_nxt;
  logic        cruise_prev_r, cruise_prev_nxt;
  logic        plus_prev_r, plus_prev_nxt;
  logic        minus_prev_r, minus_prev_nxt;
  logic        cruise_active_r, cruise_active_nxt;
  logic        brake_active_r, brake_active_nxt;
  logic        plus_flag_r, plus_flag_nxt;
  logic        minus_flag_r, minus_flag_nxt;
  logic [31:0] last_send_ms_r, last_send_ms_nxt;

  logic        out_tvalid_r, out_tvalid_nxt;
  logic [15:0] out_tdata_r, out_tdata_nxt;
  logic        out_tuser_r, out_tuser_nxt;

  // An item leaves the queue when the output register is free or draining.
  assign q_ready = !out_tvalid_r || out_tready;
  assign pop     = q_valid && q_ready;

  assign elapsed = q_item.now_ms - last_send_ms_r;
  assign pct_sum = {1'b0, q_item.pct} + {1'b0, pwm_percent_r};

  // Brake, cruise and message logic for one item.
  always_comb begin
    pwm_percent_nxt   = pwm_percent_r;
    throttle_hold_nxt = throttle_hold_r;
    brake_prev_nxt    = brake_prev_r;
    cruise_prev_nxt   = cruise_prev_r;
    plus_prev_nxt     = plus_prev_r;
    minus_prev_nxt    = minus_prev_r;
    cruise_active_nxt = cruise_active_r;
    brake_active_nxt  = brake_active_r;
    plus_upd          = plus_flag_r;
    minus_upd         = minus_flag_r;
    last_send_ms_nxt  = last_send_ms_r;
    send_due          = 1'b0;

    if (q_item.func == FUNC_PULSE) begin
      pwm_percent_nxt = q_item.pct;
    end else begin
      if (brake_prev_r && !q_item.brake) begin
        brake_active_nxt  = 1'b0;
        throttle_hold_nxt = '0;
      end
      if (!q_item.brake) begin
        if (q_item.cruise && !cruise_prev_r) begin
          cruise_active_nxt = !cruise_active_r;
        end
        cruise_prev_nxt = q_item.cruise;
        if (cruise_active_nxt) begin
          plus_upd       = plus_flag_r | (q_item.plus & ~plus_prev_r);
          minus_upd      = minus_flag_r | (q_item.minus & ~minus_prev_r);
          plus_prev_nxt  = q_item.plus;
          minus_prev_nxt = q_item.minus;
        end else begin
          throttle_hold_nxt = pct_sum[7:1];
        end
      end else begin
        brake_active_nxt  = 1'b1;
        cruise_active_nxt = 1'b0;
        throttle_hold_nxt = '0;
      end
      brake_prev_nxt = q_item.brake;
      send_due       = elapsed > {16'b0, interval};
      if (send_due) begin
        last_send_ms_nxt = q_item.now_ms;
      end
    end

    // The message carries the flags before they are cleared.
    plus_flag_nxt  = send_due ? 1'b0 : plus_upd;
    minus_flag_nxt = send_due ? 1'b0 : minus_upd;

    status            = '0;
    status[ST_CRUISE] = cruise_active_nxt;
    status[ST_PLUS]   = plus_upd;
    status[ST_MINUS]  = minus_upd;
    status[ST_BRAKE]  = brake_active_nxt;

    out_tdata_nxt = {3'b000, brake_prev_nxt, cruise_active_nxt, status, throttle_hold_nxt};
    out_tuser_nxt = send_due;
  end

  // Output register valid.
  always_comb begin
    if (pop) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_percent_r   <= '0;
      throttle_hold_r <= '0;
      brake_prev_r    <= 1'b0;
      cruise_prev_r   <= 1'b0;
      plus_prev_r     <= 1'b0;
      minus_prev_r    <= 1'b0;
      cruise_active_r <= 1'b0;
      brake_active_r  <= 1'b0;
      plus_flag_r     <= 1'b0;
      minus_flag_r    <= 1'b0;
      last_send_ms_r  <= '0;
      out_tvalid_r    <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      if (pop) begin
        pwm_percent_r   <= pwm_percent_nxt;
        throttle_hold_r <= throttle_hold_nxt;
        brake_prev_r    <= brake_prev_nxt;
        cruise_prev_r   <= cruise_prev_nxt;
        plus_prev_r     <= plus_prev_nxt;
        minus_prev_r    <= minus_prev_nxt;
        cruise_active_r <= cruise_active_nxt;
        brake_active_r  <= brake_active_nxt;
        plus_flag_r     <= plus_flag_nxt;
        minus_flag_r    <= minus_flag_nxt;
        last_send_ms_r  <= last_send_ms_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Pressing the brake cancels cruise and zeroes the throttle.
  `CTIC_ASSERT_NEXT(a_brake_cancels, clk, rst_n, pop && (q_item.func == FUNC_CONTROL) && q_item.brake, !cruise_active_r && brake_active_r && (throttle_hold_r == '0), "brake item did not cancel cruise")
  // A sent message clears the button flags and restarts the interval.
  `CTIC_ASSERT_NEXT(a_send_clears, clk, rst_n, pop && send_due, !plus_flag_r && !minus_flag_r && (last_send_ms_r == $past(q_item.now_ms)), "message did not clear flags")
  // A pulse width item leaves the cruise state alone.
  `CTIC_ASSERT_NEXT(a_pulse_keeps_state, clk, rst_n, pop && (q_item.func == FUNC_PULSE), $stable(cruise_active_r) && $stable(throttle_hold_r) && $stable(last_send_ms_r), "pulse item changed control state")
  // The throttle command never exceeds full scale.
  `CTIC_ASSERT_NOW(a_throttle_range, clk, rst_n, out_tvalid_r, out_tdata_r[6:0] <= PCT_MAX, "throttle above full scale")

endmodule

@@ hdl/cruise_throttle_input_controller.sv @@
// An accepted input item passes through the front stage, a queue entry and the
// output register before its result appears on the output.
// Throughput: one item per clock unless a side stalls; the front stage, a 2-entry
// queue and the output register let input and output stall independently.
// Each result costs one pass through the combinational state update in the back end.
// Reset (synchronous, active low) clears all controller state and sets the
// message interval to 50 ms.
module cruise_throttle_input_controller
  import ctic_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [15:0] pulse_width_us, [25:16] analog_sample, [26] brake_level,
  // [27] cruise_level, [28] plus_level, [29] minus_level, [61:30] now_ms
  input  logic [63:0]       in_tdata,
  // [0] func
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [6:0] throttle_percent, [10:7] status_bits, [11] cruise_led, [12] brake_led
  output logic [15:0]       out_tdata,
  // [0] send_valid
  output logic              out_tuser,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic        interval_wr;
  logic [15:0] interval_r, interval_nxt;
  logic        fq_valid, fq_ready;
  item_t       fq_item;
  logic        bq_valid, bq_ready;
  item_t       bq_item;

  // Configuration register.
  assign cfg_pready  = 1'b1;
  assign interval_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                       (cfg_paddr == CFG_ADDR_INTERVAL);
  assign interval_nxt = interval_wr ? cfg_pwdata[15:0] : interval_r;
  assign cfg_prdata   = (cfg_paddr == CFG_ADDR_INTERVAL) ? {16'b0, interval_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
    end else begin
      interval_r <= interval_nxt;
    end
  end

  // Front end: accept, scale and classify.
  ctic_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  // Decoupling queue.
  ctic_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_item  (bq_item)
  );

  // Back end: cruise state and message timing.
  ctic_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .interval   (interval_r),
    .q_valid    (bq_valid),
    .q_ready    (bq_ready),
    .q_item     (bq_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
